// ----- rtl/uart8n1_pkg.sv -----
`default_nettype none

package uart8n1_pkg;

   localparam int unsigned DATA_BITS_DEFAULT = 8;
   localparam int unsigned TIMER_W = 16;
   localparam int unsigned COUNT_W = 4;
   localparam logic [TIMER_W-1:0] BIT_PERIOD_RESET = 16'd5208;

   typedef struct packed {
      logic line;
      logic busy;
   } tx_out_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } rx_out_type;

endpackage

`default_nettype wire

// ----- rtl/uart8n1_tx.sv -----
`default_nettype none

module uart8n1_tx
   import uart8n1_pkg::*;
#(
   parameter int unsigned DATA_BITS = DATA_BITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               start,
   input  wire logic [7:0]         byte_in,
   input  wire logic [TIMER_W-1:0] bit_period,
   output tx_out_type              result
);

   localparam logic [1:0] TX_IDLE  = 2'd0;
   localparam logic [1:0] TX_START = 2'd1;
   localparam logic [1:0] TX_DATA  = 2'd2;
   localparam logic [1:0] TX_STOP  = 2'd3;

   logic [1:0]           phase_ff, phase_in, phase_cur;
   logic [DATA_BITS-1:0] shift_ff, shift_in, shift_cur;
   logic [COUNT_W-1:0]   bits_ff, bits_in, bits_cur;
   logic [TIMER_W-1:0]   timer_ff, timer_in, timer_cur, timer_inc;
   logic                 load;

   always_comb begin
      load      = (phase_ff == TX_IDLE) && start;
      phase_cur = load ? TX_START : phase_ff;
      shift_cur = load ? byte_in[DATA_BITS-1:0] : shift_ff;
      bits_cur  = load ? '0 : bits_ff;
      timer_cur = load ? '0 : timer_ff;
      timer_inc = timer_cur + 1'b1;

      unique case (phase_cur)
         TX_START: result.line = 1'b0;
         TX_DATA:  result.line = shift_cur[0];
         default:  result.line = 1'b1;
      endcase
      result.busy = (phase_cur != TX_IDLE);

      phase_in = phase_cur;
      shift_in = shift_cur;
      bits_in  = bits_cur;
      timer_in = timer_cur;
      if (phase_cur != TX_IDLE) begin
         timer_in = timer_inc;
         if ((timer_inc >= bit_period) || (timer_inc == '0)) begin
            timer_in = '0;
            unique case (phase_cur)
               TX_START: begin
                  phase_in = TX_DATA;
                  bits_in  = COUNT_W'(DATA_BITS);
               end
               TX_DATA: begin
                  shift_in = shift_cur >> 1;
                  bits_in  = bits_cur - 1'b1;
                  if (bits_in == '0) begin
                     phase_in = TX_STOP;
                  end
               end
               default: phase_in = TX_IDLE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= TX_IDLE;
         shift_ff <= '0;
         bits_ff  <= '0;
         timer_ff <= '0;
      end else if (en) begin
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         bits_ff  <= bits_in;
         timer_ff <= timer_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/uart8n1_rx.sv -----
`default_nettype none

module uart8n1_rx
   import uart8n1_pkg::*;
#(
   parameter int unsigned DATA_BITS = DATA_BITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               rx,
   input  wire logic [TIMER_W-1:0] bit_period,
   output rx_out_type              result
);

   localparam logic [1:0] RX_WAIT_HIGH = 2'd0;
   localparam logic [1:0] RX_HUNT      = 2'd1;
   localparam logic [1:0] RX_CHECK     = 2'd2;
   localparam logic [1:0] RX_DATA      = 2'd3;

   logic [1:0]           phase_ff, phase_in;
   logic [DATA_BITS-1:0] shift_ff, shift_in;
   logic [COUNT_W-1:0]   bits_ff, bits_in;
   logic [TIMER_W-1:0]   timer_ff, timer_in, timer_inc;

   always_comb begin
      phase_in     = phase_ff;
      shift_in     = shift_ff;
      bits_in      = bits_ff;
      timer_in     = timer_ff;
      timer_inc    = timer_ff + 1'b1;
      result.valid = 1'b0;
      result.data  = '0;

      unique case (phase_ff)
         RX_WAIT_HIGH: begin
            if (rx) begin
               phase_in = RX_HUNT;
            end
         end
         RX_HUNT: begin
            if (!rx) begin
               phase_in = RX_CHECK;
               timer_in = '0;
            end
         end
         RX_CHECK: begin
            timer_in = timer_inc;
            if (timer_inc >= (bit_period >> 1)) begin
               timer_in = '0;
               if (rx) begin
                  phase_in = RX_HUNT;
               end else begin
                  phase_in = RX_DATA;
                  shift_in = '0;
                  bits_in  = COUNT_W'(DATA_BITS);
               end
            end
         end
         default: begin
            timer_in = timer_inc;
            if ((timer_inc >= bit_period) || (timer_inc == '0)) begin
               timer_in = '0;
               shift_in = {rx, shift_ff[DATA_BITS-1:1]};
               bits_in  = bits_ff - 1'b1;
               if (bits_in == '0) begin
                  result.valid = 1'b1;
                  result.data  = 8'(shift_in);
                  phase_in     = RX_WAIT_HIGH;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= RX_WAIT_HIGH;
         shift_ff <= '0;
         bits_ff  <= '0;
         timer_ff <= '0;
      end else if (en) begin
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         bits_ff  <= bits_in;
         timer_ff <= timer_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/uart_8n1_transceiver.sv -----
// Serial 8N1 transmitter and receiver driven one clock tick per request.
//
// req channel: each request is one tick of the bit timebase and carries the
// sampled receive pin (req_rx_line) and an optional send request
// (req_tx_start with req_tx_byte). A send request made while a frame is in
// flight is dropped.
// rsp channel: exactly one response per request, in order, giving the
// transmit pin level, the busy flag and a received byte when rsp_rx_valid.
// csr channel: writes bit_period (ticks per bit); always ready. Write it
// only while no request is in flight.
//
// Path: a request is held in the input register, then its response in the
// result register, which drives the rsp channel.
// Throughput: one request per cycle unless stalled; one engine step per tick.
// Reset: both engines go idle, the receiver first waits for a high line,
// bit_period returns to 5208 and both channels empty.
// Stall: when rsp_ready is low the result register holds, the input
// register fills, and req_ready drops until responses drain.
`default_nettype none

module uart_8n1_transceiver
   import uart8n1_pkg::*;
#(
   parameter int unsigned DATA_BITS = DATA_BITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_rx_line,
   input  wire logic               req_tx_start,
   input  wire logic [7:0]         req_tx_byte,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_tx_line,
   output logic                    rsp_tx_busy,
   output logic                    rsp_rx_valid,
   output logic [7:0]              rsp_rx_byte,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [TIMER_W-1:0] csr_bit_period
);

   logic               in_valid_ff, in_valid_in;
   logic               rx_line_ff, tx_start_ff;
   logic [7:0]         tx_byte_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   tx_out_type         tx_out, tx_out_ff;
   rx_out_type         rx_out, rx_out_ff;
   logic [TIMER_W-1:0] bit_period_ff;
   logic               advance, req_fire;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         bit_period_ff <= BIT_PERIOD_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            bit_period_ff <= csr_bit_period;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rx_line_ff  <= req_rx_line;
         tx_start_ff <= req_tx_start;
         tx_byte_ff  <= req_tx_byte;
      end
      if (advance) begin
         tx_out_ff <= tx_out;
         rx_out_ff <= rx_out;
      end
   end

   uart8n1_tx #(.DATA_BITS(DATA_BITS)) u_tx (
      .clock      (clock),
      .reset      (reset),
      .en         (advance),
      .start      (tx_start_ff),
      .byte_in    (tx_byte_ff),
      .bit_period (bit_period_ff),
      .result     (tx_out)
   );

   uart8n1_rx #(.DATA_BITS(DATA_BITS)) u_rx (
      .clock      (clock),
      .reset      (reset),
      .en         (advance),
      .rx         (rx_line_ff),
      .bit_period (bit_period_ff),
      .result     (rx_out)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_tx_line  = tx_out_ff.line;
   assign rsp_tx_busy  = tx_out_ff.busy;
   assign rsp_rx_valid = rx_out_ff.valid;
   assign rsp_rx_byte  = rx_out_ff.data;

endmodule

`default_nettype wire

// ----- rtl/uart8n1_checker.sv -----
`default_nettype none

module uart8n1_checker
   import uart8n1_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               req_rx_line,
   input wire logic               req_tx_start,
   input wire logic [7:0]         req_tx_byte,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               rsp_tx_line,
   input wire logic               rsp_tx_busy,
   input wire logic               rsp_rx_valid,
   input wire logic [7:0]         rsp_rx_byte,
   input wire logic               csr_valid,
   input wire logic               csr_ready,
   input wire logic [TIMER_W-1:0] csr_bit_period
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rx_byte)
         && $stable(rsp_tx_line) && $stable(rsp_rx_valid))
      else $error("stalled response changed");

   a_idle_line_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tx_busy |-> rsp_tx_line)
      else $error("tx line low while transmitter idle");

   a_rx_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_rx_valid |-> rsp_rx_byte == 8'd0)
      else $error("rx byte nonzero without rx valid");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind uart_8n1_transceiver uart8n1_checker u_uart8n1_checker (.*);

`default_nettype wire
